@@ hdl/tfv_pkg.sv @@
// Shared types, constants and codes for the telemetry frame validator.
package tfv_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int TYPE_COUNT = 5;
    localparam int TYPE_REGS = 5;
    localparam int FRAME_OVERHEAD = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int SUM_W = 16 + $clog2(MAX_FRAME_BYTES);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_BAD_TYPE = 3'd2,
        ST_LEN      = 3'd3,
        ST_SUM      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        REG_MIN_LEN = 3'd0,
        REG_PLEN0   = 3'd1,
        REG_PLEN1   = 3'd2,
        REG_PLEN2   = 3'd3,
        REG_PLEN3   = 3'd4,
        REG_PLEN4   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]                  min_len;
        logic [TYPE_REGS-1:0][7:0]   payload_len;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic [SUM_W-1:0] sum;
        logic             pad;
        logic [7:0]       frame_type;
        logic [15:0]      rx_sum;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ hdl/telemetry_frame_validator.sv @@
// Top level of the telemetry frame validator: configuration, front end, queue and back end.
// Throughput: one byte transfer per cycle while not stalled; one verdict transfer per cycle at most.
// The verdict passes through the queue write, the two back-end stages (pad add, first checksum fold)
// and the output register, which takes the second fold; an output stall holds every stage.
// A full two-entry queue stalls the input; it only fills while the output side is stalled.
// Synchronous active-low reset clears frame state, queue and pipeline, and loads register defaults.
module telemetry_frame_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_ok,
    output logic [2:0]  o_status,
    output logic [7:0]  o_frame_type,
    output logic [8:0]  o_frame_length,
    output logic [15:0] o_computed_sum,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import tfv_pkg::*;

    t_cfg       r_cfg;
    t_frame_rec front_rec, q_head;
    t_q_status  q_status;
    logic       in_accept, push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_len        <= 8'd7;
            r_cfg.payload_len[0] <= 8'd1;
            r_cfg.payload_len[1] <= 8'd50;
            r_cfg.payload_len[2] <= 8'd21;
            r_cfg.payload_len[3] <= 8'd21;
            r_cfg.payload_len[4] <= 8'd13;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MIN_LEN) begin
                r_cfg.min_len <= i_cfg_data;
            end else if ((i_cfg_index >= REG_PLEN0) && (i_cfg_index <= REG_PLEN4)) begin
                r_cfg.payload_len[3'(i_cfg_index - REG_PLEN0)] <= i_cfg_data;
            end
        end
    end

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    tfv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_rec       (front_rec)
    );

    tfv_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (front_rec),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    tfv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (q_head),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_frame_ok     (o_frame_ok),
        .o_status       (o_status),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length),
        .o_computed_sum (o_computed_sum)
    );

    a_ok_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_ok == (o_status == ST_OK)))
        else $error("frame_ok disagrees with status");

    a_ok_frame_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_ok) |->
            ((o_frame_type < 8'(TYPE_COUNT)) && (o_frame_length >= 9'(FRAME_OVERHEAD))))
        else $error("good frame with impossible type or length");

    a_queue_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("frame record pushed into a full queue");

endmodule

@@ hdl/tfv_front.sv @@
// Front end: accepts frame bytes, tracks length, type and running sum, emits a frame record.
module tfv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_push,
    output tfv_pkg::t_frame_rec o_rec
);
    import tfv_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_high, n_high;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_newer, n_newer;
    logic [7:0]       r_older, n_older;
    logic [7:0]       inv_byte;
    logic [SUM_W-1:0] add_val;

    always_comb begin
        n_cnt   = r_cnt;
        n_high  = r_high;
        n_sum   = r_sum;
        n_type  = r_type;
        n_newer = r_newer;
        n_older = r_older;
        inv_byte = r_older ^ 8'hFF;
        add_val = r_high ? SUM_W'({inv_byte, 8'h00}) : SUM_W'(inv_byte);
        if (i_accept && (r_cnt < CNT_W'(MAX_FRAME_BYTES))) begin
            if (r_cnt >= CNT_W'(2)) begin
                n_sum  = r_sum + add_val;
                n_high = !r_high;
            end
            if (r_cnt == CNT_W'(4)) begin
                n_type = i_data_byte;
            end
            n_older = r_newer;
            n_newer = i_data_byte;
            n_cnt   = r_cnt + CNT_W'(1);
        end
    end

    assign o_push           = i_accept && i_last_byte;
    assign o_rec.len        = n_cnt;
    assign o_rec.sum        = n_sum;
    assign o_rec.pad        = !n_high;
    assign o_rec.frame_type = n_type;
    assign o_rec.rx_sum     = {n_newer, n_older};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_cnt   <= '0;
            r_high  <= 1'b1;
            r_sum   <= '0;
            r_type  <= '0;
            r_newer <= '0;
            r_older <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_high  <= n_high;
            r_sum   <= n_sum;
            r_type  <= n_type;
            r_newer <= n_newer;
            r_older <= n_older;
        end
    end

endmodule

@@ hdl/tfv_queue.sv @@
// Short queue of frame records between the front end and the back end.
module tfv_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tfv_pkg::t_frame_rec i_rec,
    input  logic                i_pop,
    output tfv_pkg::t_frame_rec o_head,
    output tfv_pkg::t_q_status  o_status
);
    import tfv_pkg::*;

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

@@ hdl/tfv_back.sv @@
// Back end: folds the checksum, runs the frame checks and holds the verdict.
module tfv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tfv_pkg::t_cfg       i_cfg,
    input  tfv_pkg::t_frame_rec i_head,
    input  tfv_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_frame_ok,
    output logic [2:0]          o_status,
    output logic [7:0]          o_frame_type,
    output logic [8:0]          o_frame_length,
    output logic [15:0]         o_computed_sum
);
    import tfv_pkg::*;

    logic             advance;
    logic             r_s1_valid, r_s2_valid, r_out_valid;
    logic [SUM_W-1:0] r_s1_sum;
    t_status          r_s1_pre, r_s2_pre, n_pre;
    logic [16:0]      r_s2_fold;
    logic [CNT_W-1:0] r_s1_len, r_s2_len;
    logic [7:0]       r_s1_type, r_s2_type;
    logic [15:0]      r_s1_rx, r_s2_rx;
    logic [15:0]      fold2;
    logic [CMP_W-1:0] exp_len;
    t_status          r_status, n_status;
    logic [7:0]       r_type;
    logic [8:0]       r_len;
    logic [15:0]      r_sum;

    assign advance = !r_out_valid || !i_stall;
    assign o_pop   = advance && !i_q_status.empty;

    always_comb begin
        exp_len = CMP_W'(i_cfg.payload_len[i_head.frame_type[2:0]]) + CMP_W'(FRAME_OVERHEAD);
        if (CMP_W'(i_head.len) < CMP_W'(i_cfg.min_len)) begin
            n_pre = ST_SHORT;
        end else if (i_head.frame_type >= 8'(TYPE_COUNT)) begin
            n_pre = ST_BAD_TYPE;
        end else if (CMP_W'(i_head.len) != exp_len) begin
            n_pre = ST_LEN;
        end else begin
            n_pre = ST_OK;
        end
    end

    always_comb begin
        fold2 = 16'(r_s2_fold[16]) + r_s2_fold[15:0];
        if ((r_s2_pre == ST_OK) && (fold2 != r_s2_rx)) begin
            n_status = ST_SUM;
        end else begin
            n_status = r_s2_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_sum  <= i_head.sum + (i_head.pad ? SUM_W'(8'hFF) : SUM_W'(0));
            r_s1_pre  <= n_pre;
            r_s1_len  <= i_head.len;
            r_s1_type <= i_head.frame_type;
            r_s1_rx   <= i_head.rx_sum;
            r_s2_fold <= 17'(r_s1_sum[SUM_W-1:16]) + 17'(r_s1_sum[15:0]);
            r_s2_pre  <= r_s1_pre;
            r_s2_len  <= r_s1_len;
            r_s2_type <= r_s1_type;
            r_s2_rx   <= r_s1_rx;
            r_status  <= n_status;
            r_type    <= r_s2_type;
            r_len     <= 9'(r_s2_len);
            r_sum     <= fold2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= !i_q_status.empty;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_frame_ok     = (r_status == ST_OK);
    assign o_frame_type   = r_type;
    assign o_frame_length = r_len;
    assign o_computed_sum = r_sum;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the telemetry frame validator with a built-in frame checker.
`timescale 1ns / 100ps

module testbench;
    import tfv_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam bit [2:0] SPARE_IDX_LO = 3'd6;
    localparam bit [2:0] SPARE_IDX_HI = 3'd7;

    typedef bit [7:0] octet_t;

    typedef struct {
        octet_t data;
        bit     last;
    } byte_xfer_t;

    typedef struct {
        bit         ok;
        t_status    status;
        octet_t     ftype;
        bit [8:0]   length;
        bit [15:0]  sum;
    } frame_verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_frame_ok;
    logic [2:0]  o_status;
    logic [7:0]  o_frame_type;
    logic [8:0]  o_frame_length;
    logic [15:0] o_computed_sum;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [7:0]  i_cfg_data = 8'h00;

    byte_xfer_t     byte_backlog[$];
    octet_t         frame_bytes[$];
    frame_verdict_t verdicts_due[$];

    bit [7:0] min_len_cfg = 8'd7;
    bit [7:0] plen_cfg [TYPE_REGS] = '{8'd1, 8'd50, 8'd21, 8'd21, 8'd13};

    int fail_count = 0;
    int bytes_sent = 0;
    int verdicts_checked = 0;
    int settings_used = 1;
    int status_seen [5] = '{0, 0, 0, 0, 0};
    int cycle_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int stall_left = 0;
    int recv_calm = 0;
    int hold_left = 0;
    bit hold_wanted = 1'b0;
    bit hold_started = 1'b0;
    int bytes_queued = 0;

    telemetry_frame_validator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_ok     (o_frame_ok),
        .o_status       (o_status),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length),
        .o_computed_sum (o_computed_sum),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d verdicts outstanding.",
                     cycle_count, verdicts_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Complemented bytes are paired big-endian; an odd tail is padded with 0xFF.
    function automatic bit [15:0] complement_sum(input octet_t fr[$], input int count);
        bit [31:0] acc;
        bit [31:0] folded;
        acc = 32'd0;
        for (int i = 0; i < count; i++) begin
            if (i % 2 == 0) acc += {16'h0000, ~fr[i], 8'h00};
            else acc += {24'h000000, ~fr[i]};
        end
        if (count % 2 == 1) acc += 32'h0000_00FF;
        folded = {16'h0000, acc[31:16]} + {16'h0000, acc[15:0]};
        folded = {16'h0000, folded[31:16]} + {16'h0000, folded[15:0]};
        return folded[15:0];
    endfunction

    function automatic void note_reg_write(bit [2:0] idx, bit [7:0] val);
        case (idx)
            REG_MIN_LEN: min_len_cfg = val;
            REG_PLEN0:   plen_cfg[0] = val;
            REG_PLEN1:   plen_cfg[1] = val;
            REG_PLEN2:   plen_cfg[2] = val;
            REG_PLEN3:   plen_cfg[3] = val;
            REG_PLEN4:   plen_cfg[4] = val;
            default: ;
        endcase
    endfunction

    // Bytes past the buffer size are dropped, the final one included.
    function automatic void record_byte(octet_t b, bit last);
        frame_verdict_t v;
        int n;
        octet_t ftype;
        bit [15:0] rx;
        if (frame_bytes.size() < MAX_FRAME_BYTES) frame_bytes.push_back(b);
        if (!last) return;
        n = frame_bytes.size();
        ftype = (n > 4) ? frame_bytes[4] : 8'h00;
        rx = {frame_bytes[n-1], (n >= 2) ? frame_bytes[n-2] : 8'h00};
        v.sum = complement_sum(frame_bytes, (n >= 2) ? n - 2 : 0);
        if (n < min_len_cfg) v.status = ST_SHORT;
        else if (ftype >= TYPE_COUNT) v.status = ST_BAD_TYPE;
        else if (n != plen_cfg[ftype] + FRAME_OVERHEAD) v.status = ST_LEN;
        else if (v.sum != rx) v.status = ST_SUM;
        else v.status = ST_OK;
        v.ok = (v.status == ST_OK);
        v.ftype = ftype;
        v.length = 9'(n);
        verdicts_due.push_back(v);
        status_seen[v.status]++;
        frame_bytes.delete();
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : byte_driver
        byte_xfer_t item;
        if (i_in_valid && !o_in_stall) begin
            record_byte(i_data_byte, i_last_byte);
            bytes_sent++;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (byte_backlog.size() > 0) begin
                item = byte_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_data_byte <= item.data;
                i_last_byte <= item.last;
                send_gap = pick_gap(send_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : verdict_monitor
        frame_verdict_t v;
        if (o_out_valid && !i_out_stall) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected verdict transfer, status %0d, length %0d",
                         $time, o_status, o_frame_length);
                fail_count++;
            end else begin
                v = verdicts_due.pop_front();
                check_field("frame_ok", 16'(v.ok), 16'(o_frame_ok));
                check_field("status", 16'(v.status), 16'(o_status));
                check_field("frame_type", 16'(v.ftype), 16'(o_frame_type));
                check_field("frame_length", 16'(v.length), 16'(o_frame_length));
                check_field("computed_sum", v.sum, o_computed_sum);
                verdicts_checked++;
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_wanted && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_gap(recv_calm);
        end
    end

    task automatic write_reg(bit [2:0] idx, bit [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        note_reg_write(idx, val);
    endtask

    task automatic apply_settings(bit [7:0] min_len, bit [7:0] plens [TYPE_REGS]);
        write_reg(REG_MIN_LEN, min_len);
        for (int t = 0; t < TYPE_REGS; t++) write_reg(REG_PLEN0 + 3'(t), plens[t]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    task automatic settle();
        while (byte_backlog.size() != 0 || i_in_valid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // A negative fill gives random content; the last two bytes carry the checksum.
    task automatic queue_frame(int len, octet_t ftype, bit sum_ok, int fill);
        octet_t fr[$];
        bit [15:0] sum;
        for (int i = 0; i < len; i++)
            fr.push_back((fill < 0) ? octet_t'($urandom_range(0, 255)) : octet_t'(fill));
        if (len > 4) fr[4] = ftype;
        if (len >= 2) begin
            sum = complement_sum(fr, len - 2);
            if (!sum_ok) sum ^= 16'(1 << $urandom_range(0, 15));
            fr[len-2] = sum[7:0];
            fr[len-1] = sum[15:8];
        end
        for (int i = 0; i < len; i++) byte_backlog.push_back('{data: fr[i], last: i == len - 1});
        bytes_queued += len;
    endtask

    task automatic queue_random_frame();
        int kind;
        int t;
        int len;
        kind = $urandom_range(0, 99);
        t = $urandom_range(0, TYPE_COUNT - 1);
        for (int k = 0; k < TYPE_COUNT && plen_cfg[t] > 40; k++) t = (t + 1) % TYPE_COUNT;
        len = plen_cfg[t] + FRAME_OVERHEAD;
        if (kind < 65) begin
            queue_frame(len, octet_t'(t), 1'b1, -1);
        end else if (kind < 75) begin
            queue_frame(len, octet_t'(t), 1'b0, -1);
        end else if (kind < 82) begin
            len = $urandom_range(5, 30);
            queue_frame(len, octet_t'($urandom_range(TYPE_COUNT, 255)), 1'b1, -1);
        end else if (kind < 90) begin
            if ($urandom_range(0, 1)) len += $urandom_range(1, 3);
            else len -= $urandom_range(1, 3);
            if (len < 1) len = 1;
            queue_frame(len, octet_t'(t), 1'b1, -1);
        end else if (kind < 97) begin
            len = $urandom_range(1, 8);
            queue_frame(len, octet_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), -1);
        end else begin
            len = $urandom_range(1, 40);
            queue_frame(len, octet_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), -1);
        end
    endtask

    initial begin : stimulus
        bit [7:0] plens [TYPE_REGS];
        int phase;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: tiny frame, good type-0 frame filled with 0xFF, bad type, bad checksum.
        queue_frame(2, 8'h00, 1'b1, 8'h00);
        queue_frame(8, 8'h00, 1'b1, 8'hFF);
        queue_frame(7, 8'hFF, 1'b1, 8'h00);
        queue_frame(8, 8'h00, 1'b0, -1);
        settle();

        plens = '{8'd0, 8'd248, 8'd1, 8'd4, 8'd2};
        apply_settings(8'd0, plens);
        write_reg(SPARE_IDX_LO, 8'hFF);
        write_reg(SPARE_IDX_HI, 8'h00);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        repeat (3) queue_random_frame();
        queue_frame(258, 8'd0, 1'b1, -1);
        repeat (2) queue_random_frame();
        settle();

        plens = '{8'd248, 8'd0, 8'd0, 8'd0, 8'd0};
        apply_settings(8'd255, plens);
        repeat (3) queue_random_frame();
        settle();

        phase = 0;
        while (bytes_queued < 550 || phase == 0) begin
            for (int t = 0; t < TYPE_REGS; t++) plens[t] = 8'($urandom_range(0, 20));
            apply_settings(8'($urandom_range(0, 25)), plens);
            if (phase == 0) begin
                hold_wanted = 1'b1;
                repeat (10) queue_random_frame();
            end else begin
                repeat ($urandom_range(5, 8)) queue_random_frame();
            end
            settle();
            phase++;
        end

        $display("Checked %0d verdicts from %0d byte transfers under %0d register settings.",
                 verdicts_checked, bytes_sent, settings_used);
        $display("Verdicts: ok %0d, short %0d, bad type %0d, length %0d, checksum %0d.",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_BAD_TYPE],
                 status_seen[ST_LEN], status_seen[ST_SUM]);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
